FILE: sv/fcd_pkg.sv
// fcd_pkg: shared types and constants for the framed command decoder.
// No dependencies; imported by the interfaces, the bench and every module of the block but fcd_checker.

package fcd_pkg;

   // Payload store geometry
   localparam int PAYLOAD_DEPTH = 4;
   localparam int FILL_W        = $clog2(PAYLOAD_DEPTH) + 1;
   localparam int SLOT_W        = $clog2(PAYLOAD_DEPTH);

   // Configuration register map
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_START_BYTE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_END_BYTE   = 2'd1;

   // Register reset values
   localparam logic [7:0] START_RESET = 8'hAA;
   localparam logic [7:0] END_RESET   = 8'hF7;

   typedef logic [7:0] rx_byte_type;

   typedef logic [PAYLOAD_DEPTH-1:0][7:0] store_type;

   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] end_byte;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  mode_value;
      logic [7:0]  dump_time;
      logic [14:0] time_hundredths;
      logic [4:0]  digit_thousands;
      logic [3:0]  digit_hundreds;
      logic [3:0]  digit_tens;
      logic [3:0]  digit_units;
   } result_type;

endpackage

FILE: sv/fcd_if.sv
// fcd_if: handshake channels of the framed command decoder (byte in, result out, CSR writes).
// Depends on fcd_pkg for the CSR index width.

interface fcd_req_if import fcd_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fcd_rsp_if import fcd_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [7:0]  mode_value;
   logic [7:0]  dump_time;
   logic [14:0] time_hundredths;
   logic [4:0]  digit_thousands;
   logic [3:0]  digit_hundreds;
   logic [3:0]  digit_tens;
   logic [3:0]  digit_units;

   modport source (output valid, input ready, output mode_value, output dump_time,
                   output time_hundredths, output digit_thousands, output digit_hundreds,
                   output digit_tens, output digit_units);
   modport sink   (input valid, output ready, input mode_value, input dump_time,
                   input time_hundredths, input digit_thousands, input digit_hundreds,
                   input digit_tens, input digit_units);
endinterface

interface fcd_csr_if import fcd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [7:0]           wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: sv/fcd_csr_regs.sv
// fcd_csr_regs: start and end byte configuration registers.
// Depends on fcd_pkg and fcd_csr_if.

module fcd_csr_regs import fcd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   fcd_csr_if.sink      csr,
   output cfg_type      cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken; unknown indexes are dropped
   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            REG_START_BYTE: cfg_in.start_byte = csr.wdata;
            REG_END_BYTE:   cfg_in.end_byte   = csr.wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte <= START_RESET;
         cfg_ff.end_byte   <= END_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/fcd_frame_ctrl.sv
// fcd_frame_ctrl: frame state (collecting flag, fill index) and the four-entry payload store.
// Depends on fcd_pkg.

module fcd_frame_ctrl import fcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  rx_byte_type rx_byte,
   input  cfg_type     cfg,
   output logic        is_end,
   output store_type   store
);

   logic              collecting_ff, collecting_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   store_type         store_ff, store_in;
   logic              is_start;
   logic              room;

   assign is_end   = (rx_byte == cfg.end_byte);
   assign is_start = (rx_byte == cfg.start_byte);
   assign room     = (fill_ff < FILL_W'(PAYLOAD_DEPTH));

   // End clears collecting first, then store if room, then start restarts
   always_comb begin
      collecting_in = collecting_ff;
      fill_in       = fill_ff;
      store_in      = store_ff;
      if (step) begin
         if (is_end) begin
            collecting_in = 1'b0;
         end
         if (collecting_ff && !is_end && room) begin
            store_in[fill_ff[SLOT_W-1:0]] = rx_byte;
            fill_in                       = fill_ff + FILL_W'(1);
         end
         if (is_start) begin
            collecting_in = 1'b1;
            fill_in       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         fill_ff       <= '0;
         store_ff      <= '0;
      end else begin
         collecting_ff <= collecting_in;
         fill_ff       <= fill_in;
         store_ff      <= store_in;
      end
   end

   assign store = store_ff;

endmodule

FILE: sv/fcd_time_decode.sv
// fcd_time_decode: combinational decode of the payload store into mode, dump time and digits.
// Depends on fcd_pkg. Digits come from splitting byte3 by 100 so only small divides by 10 remain.

module fcd_time_decode import fcd_pkg::*; (
   input  store_type  store,
   output result_type res
);

   logic [7:0]  b2, b3;
   logic [1:0]  b3_hund;
   logic [6:0]  b3_rem;
   logic [8:0]  hund_total;
   logic [15:0] thou_prod;
   logic [4:0]  thou_q;
   logic [14:0] rem_prod;
   logic [3:0]  tens_q;
   logic [14:0] scaled_b2;

   assign b2 = store[2];
   assign b3 = store[3];

   // byte3 = b3_hund*100 + b3_rem, b3_rem below 100
   always_comb begin
      if (b3 >= 8'd200) begin
         b3_hund = 2'd2;
         b3_rem  = 7'(b3 - 8'd200);
      end else if (b3 >= 8'd100) begin
         b3_hund = 2'd1;
         b3_rem  = 7'(b3 - 8'd100);
      end else begin
         b3_hund = 2'd0;
         b3_rem  = b3[6:0];
      end
   end

   // time / 100 = byte2 + b3_hund, time % 100 = b3_rem
   assign hund_total = {1'b0, b2} + {7'd0, b3_hund};

   // Divide by 10 as multiply by 205 then shift by 11, exact below 1029
   assign thou_prod = 16'({7'd0, hund_total} * 16'd205);
   assign thou_q    = thou_prod[15:11];
   assign rem_prod  = 15'({8'd0, b3_rem} * 15'd205);
   assign tens_q    = rem_prod[14:11];

   // byte2 * 100 as shifts: 64 + 32 + 4
   assign scaled_b2 = {1'b0, b2, 6'd0} + {2'd0, b2, 5'd0} + {5'd0, b2, 2'd0};

   always_comb begin
      res.mode_value      = store[0];
      res.dump_time       = store[1];
      res.time_hundredths = scaled_b2 + {7'd0, b3};
      res.digit_thousands = thou_q;
      res.digit_hundreds  = 4'(hund_total - 9'({4'd0, thou_q} * 9'd10));
      res.digit_tens      = tens_q;
      res.digit_units     = 4'(b3_rem - 7'({3'd0, tens_q} * 7'd10));
   end

endmodule

FILE: sv/framed_command_decoder.sv
// framed_command_decoder: start/end byte frame receiver with payload decode (top level).
// Depends on fcd_pkg, fcd_if, fcd_csr_regs, fcd_frame_ctrl and fcd_time_decode.
//
//   channel  | dir | handshake     | word
//   ---------+-----+---------------+-------------------------------------------------
//   req_ch   | in  | valid/ready   | rx_byte (8)
//   rsp_ch   | out | valid/ready   | mode_value, dump_time, time_hundredths, 4 digits
//   csr_ch   | in  | valid/ready   | index (0 start_byte, 1 end_byte), wdata (8)
//
// One byte a cycle while no end byte is held by a stalled result: a word accepted lands in
// the input register; as it leaves it, the frame state updates and, for an end byte, the
// decode is loaded into the result register.
// A stalled result only holds back end bytes; other bytes keep flowing behind it.
// Synchronous reset clears the frame state, payload store and valid flags and sets the
// CSRs to their defaults; the data registers are not reset. csr_ch is always ready.

module framed_command_decoder import fcd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   fcd_req_if.sink   req_ch,
   fcd_rsp_if.source rsp_ch,
   fcd_csr_if.sink   csr_ch
);

   cfg_type     cfg;
   store_type   store;
   result_type  decoded;
   logic        is_end;

   logic        in_valid_ff, in_valid_in;
   rx_byte_type in_byte_ff, in_byte_in;
   logic        out_valid_ff, out_valid_in;
   result_type  out_res_ff, out_res_in;

   logic        out_ready;
   logic        retire;
   logic        req_take;

   fcd_csr_regs u_csr_regs (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .cfg   (cfg)
   );

   fcd_frame_ctrl u_frame_ctrl (
      .clock   (clock),
      .reset   (reset),
      .step    (retire),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .is_end  (is_end),
      .store   (store)
   );

   fcd_time_decode u_time_decode (
      .store (store),
      .res   (decoded)
   );

   // Handshake: a byte leaves the input register unless it is an end byte facing a full output
   assign out_ready    = !out_valid_ff || rsp_ch.ready;
   assign retire       = in_valid_ff && (!is_end || out_ready);
   assign req_ch.ready = !in_valid_ff || retire;
   assign req_take     = req_ch.valid && req_ch.ready;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_ch.rx_byte;
      end else if (retire) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (retire && is_end) begin
         out_valid_in = 1'b1;
         out_res_in   = decoded;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.mode_value      = out_res_ff.mode_value;
   assign rsp_ch.dump_time       = out_res_ff.dump_time;
   assign rsp_ch.time_hundredths = out_res_ff.time_hundredths;
   assign rsp_ch.digit_thousands = out_res_ff.digit_thousands;
   assign rsp_ch.digit_hundreds  = out_res_ff.digit_hundreds;
   assign rsp_ch.digit_tens      = out_res_ff.digit_tens;
   assign rsp_ch.digit_units     = out_res_ff.digit_units;

endmodule

FILE: sv/fcd_checker.sv
// fcd_checker: port-level assertions on the result channel of the framed command decoder.
// Depends on framed_command_decoder; attached by the bind statement at the end of this file.

module fcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  mode_value,
   input logic [7:0]  dump_time,
   input logic [14:0] time_hundredths,
   input logic [4:0]  digit_thousands,
   input logic [3:0]  digit_hundreds,
   input logic [3:0]  digit_tens,
   input logic [3:0]  digit_units
);

   // A result word stays offered until taken
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word withdrawn before it was taken");

   // A stalled result word keeps its contents
   a_word_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(mode_value) && $stable(dump_time)
         && $stable(time_hundredths) && $stable(digit_thousands)
         && $stable(digit_hundreds) && $stable(digit_tens) && $stable(digit_units))
      else $error("stalled result word changed");

   // Digits stay in their ranges
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> digit_thousands <= 5'd25 && digit_hundreds <= 4'd9
         && digit_tens <= 4'd9 && digit_units <= 4'd9)
      else $error("decoded digit out of range");

   // Digits recompose the time value
   a_digit_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(time_hundredths) == 32'(digit_thousands) * 32'd1000
         + 32'(digit_hundreds) * 32'd100 + 32'(digit_tens) * 32'd10 + 32'(digit_units))
      else $error("digits do not match time value");

endmodule

bind framed_command_decoder fcd_checker u_fcd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .mode_value      (rsp_ch.mode_value),
   .dump_time       (rsp_ch.dump_time),
   .time_hundredths (rsp_ch.time_hundredths),
   .digit_thousands (rsp_ch.digit_thousands),
   .digit_hundreds  (rsp_ch.digit_hundreds),
   .digit_tens      (rsp_ch.digit_tens),
   .digit_units     (rsp_ch.digit_units)
);

FILE: test/tb.sv
// tb: self-checking bench for framed_command_decoder, driving bytes in and checking decodes out.
// Depends on fcd_pkg, the fcd_*_if channel interfaces and the framed_command_decoder RTL.
// A directed table comes first, then randomised frames over several start/end byte settings.

module tb import fcd_pkg::*; ();

   localparam int HOLD_OFF   = 4;     // cycles for the input register to drain before CSR writes
   localparam int TAIL       = 8;     // cycles allowed for stray words at the end
   localparam int STALL_MAX  = 500;   // cycles with no handshake before the run is abandoned
   localparam int PHASE_SIZE = 80;    // bytes per random phase
   localparam int NUM_PROBES = 26;

   // index with no register behind it, writes must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [7:0] rx;
      logic       typed;
      result_type want;
   } probe_row;

   localparam result_type R_ZERO = '{8'h00, 8'h00, 15'd0, 5'd0, 4'd0, 4'd0, 4'd0};
   localparam result_type R_304  = '{8'h01, 8'h02, 15'd304, 5'd0, 4'd3, 4'd0, 4'd4};
   localparam result_type R_MAX  = '{8'hFF, 8'hFF, 15'd25755, 5'd25, 4'd7, 4'd5, 4'd5};

   // directed bytes under reset framing; typed rows carry a hand-worked decode
   localparam probe_row PROBES [NUM_PROBES] = '{
      // end byte straight after reset decodes the cleared store
      '{END_RESET,   1'b1, R_ZERO},
      // plain frame
      '{START_RESET, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h02, 1'b0, '0},
      '{8'h03,       1'b0, '0}, '{8'h04, 1'b0, '0}, '{END_RESET, 1'b1, R_304},
      // largest payload, largest time value
      '{START_RESET, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
      '{8'hFF,       1'b0, '0}, '{8'hFF, 1'b0, '0}, '{END_RESET, 1'b1, R_MAX},
      // store full: the fifth payload byte is dropped
      '{START_RESET, 1'b0, '0}, '{8'h10, 1'b0, '0}, '{8'h20, 1'b0, '0},
      '{8'h30,       1'b0, '0}, '{8'h40, 1'b0, '0}, '{8'h50, 1'b0, '0},
      '{END_RESET,   1'b0, '0},
      // start byte mid-frame is stored, then restarts; short frame keeps old entries
      '{START_RESET, 1'b0, '0}, '{8'h11, 1'b0, '0}, '{START_RESET, 1'b0, '0},
      '{8'h22,       1'b0, '0}, '{8'h33, 1'b0, '0}, '{END_RESET, 1'b0, '0}
   };

   logic clock;
   logic reset;

   fcd_req_if req_ch ();
   fcd_rsp_if rsp_ch ();
   fcd_csr_if csr_ch ();

   framed_command_decoder uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor state
   cfg_type           framing;
   logic              frame_open;
   logic [FILL_W-1:0] fill_pos;
   store_type         frame_store;
   result_type        decode_queue [$];

   // per-word side information from the driver
   bit         hand_typed;
   result_type hand_result;

   bit idle_on = 1'b1;
   int hold_left = 0;
   int error_count = 0;
   int bytes_sent = 0;
   int decodes_checked = 0;
   int settings_run = 1;

   always #1 clock = ~clock;

   // decode of the payload store as it stands
   function automatic result_type decode_store(input store_type s);
      result_type  r;
      int unsigned t;
      t = int'(s[2]) * 100 + int'(s[3]);
      r.mode_value      = s[0];
      r.dump_time       = s[1];
      r.time_hundredths = t[14:0];
      r.digit_thousands = 5'(t / 1000);
      r.digit_hundreds  = 4'((t / 100) % 10);
      r.digit_tens      = 4'((t / 10) % 10);
      r.digit_units     = 4'(t % 10);
      return r;
   endfunction

   // frame state update for one received byte; returns 1 when a decode is due
   function automatic bit frame_byte(input logic [7:0] b, output result_type r);
      bit fire;
      fire = 1'b0;
      r    = '0;
      if (b == framing.end_byte) begin
         frame_open = 1'b0;
         r          = decode_store(frame_store);
         fire       = 1'b1;
      end
      if (frame_open && fill_pos < PAYLOAD_DEPTH) begin
         frame_store[fill_pos[SLOT_W-1:0]] = b;
         fill_pos++;
      end
      if (b == framing.start_byte) begin
         frame_open = 1'b1;
         fill_pos   = '0;
      end
      return fire;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // monitor: predict on accepted bytes, check accepted result words, mirror CSR writes
   always @(posedge clock) begin
      result_type r;
      result_type want;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == REG_START_BYTE) framing.start_byte = csr_ch.wdata;
            else if (csr_ch.index == REG_END_BYTE) framing.end_byte = csr_ch.wdata;
         end
         if (req_ch.valid && req_ch.ready) begin
            if (frame_byte(req_ch.rx_byte, r))
               decode_queue.push_back(hand_typed ? hand_result : r);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (decode_queue.size() == 0) begin
               $error("result word with no decode pending");
               error_count++;
            end else begin
               want = decode_queue.pop_front();
               check_field("mode_value", want.mode_value, rsp_ch.mode_value);
               check_field("dump_time", want.dump_time, rsp_ch.dump_time);
               check_field("time_hundredths", want.time_hundredths, rsp_ch.time_hundredths);
               check_field("digit_thousands", want.digit_thousands, rsp_ch.digit_thousands);
               check_field("digit_hundreds", want.digit_hundreds, rsp_ch.digit_hundreds);
               check_field("digit_tens", want.digit_tens, rsp_ch.digit_tens);
               check_field("digit_units", want.digit_units, rsp_ch.digit_units);
               decodes_checked++;
            end
         end
      end
   end

   // result back-pressure in random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left = $urandom_range(1, 6) - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // watchdog: too long without any handshake
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_MAX) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no handshake for %0d cycles", STALL_MAX);
      $display("Simulation FAILED");
      $finish;
   end

   // one byte word; called and returns at a falling edge, leaves valid high
   task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input result_type want = '0);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      hand_typed    = typed;
      hand_result   = want;
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= data;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
   endtask

   // stop sending and wait for every pending decode, then let the pipeline empty
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (decode_queue.size() != 0) @(negedge clock);
      repeat (HOLD_OFF) @(negedge clock);
   endtask

   task automatic set_framing(input logic [7:0] s, input logic [7:0] e);
      drain();
      write_csr(REG_START_BYTE, s);
      write_csr(REG_END_BYTE, e);
      write_csr(REG_UNMAPPED, 8'($urandom_range(0, 255)));
      csr_ch.valid <= 1'b0;
      settings_run++;
   endtask

   // one random frame: mostly well formed, some short, long, restarted, plain noise or a lone end byte
   task automatic send_frame();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
         send_byte(framing.start_byte);
         repeat (4) send_byte(8'($urandom_range(0, 255)));
         send_byte(framing.end_byte);
      end else if (kind == 6) begin
         send_byte(framing.start_byte);
         repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(0, 255)));
         send_byte(framing.end_byte);
      end else if (kind == 7) begin
         send_byte(framing.start_byte);
         repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
         send_byte(framing.start_byte);
         repeat (4) send_byte(8'($urandom_range(0, 255)));
         send_byte(framing.end_byte);
      end else if (kind == 8) begin
         repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
      end else begin
         send_byte(framing.end_byte);
      end
   endtask

   task automatic random_phase();
      int stop_at;
      stop_at = bytes_sent + PHASE_SIZE;
      while (bytes_sent < stop_at) send_frame();
   endtask

   initial begin
      logic [7:0] v;
      clock          = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = '0;
      csr_ch.wdata   = '0;
      rsp_ch.ready   = 1'b0;
      framing.start_byte = START_RESET;
      framing.end_byte   = END_RESET;
      frame_open  = 1'b0;
      fill_pos    = '0;
      frame_store = '0;
      hand_typed  = 1'b0;
      hand_result = '0;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table under reset framing
      for (int i = 0; i < NUM_PROBES; i++)
         send_byte(PROBES[i].rx, PROBES[i].typed, PROBES[i].want);

      // random frames over a range of framing bytes
      set_framing(8'h00, 8'hFF);
      random_phase();
      set_framing(8'hFF, 8'h00);
      random_phase();
      v = 8'($urandom_range(0, 255));
      set_framing(v, v);
      random_phase();
      set_framing(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      random_phase();

      // last stretch at full rate, back to the reset framing
      idle_on = 1'b0;
      set_framing(START_RESET, END_RESET);
      random_phase();

      drain();
      repeat (TAIL) @(posedge clock);

      $display("Sent %0d bytes under %0d framing settings; %0d decodes checked.",
               bytes_sent, settings_run, decodes_checked);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: files.f
sv/fcd_pkg.sv
sv/fcd_if.sv
sv/fcd_csr_regs.sv
sv/fcd_frame_ctrl.sv
sv/fcd_time_decode.sv
sv/framed_command_decoder.sv
sv/fcd_checker.sv
test/tb.sv
